### rtl/utfhp_pkg.sv
// Shared types and constants for the tunnelled UDP frame header parser.
// Used by every module in rtl/; depends on nothing else.

package utfhp_pkg;

	// Role tag carried with each word
	typedef enum logic [2:0] {
		ROLE_TYPE    = 3'd0,
		ROLE_DOM_LEN = 3'd1,
		ROLE_ADDR    = 3'd2,
		ROLE_PORT    = 3'd3,
		ROLE_LENGTH  = 3'd4,
		ROLE_CR      = 3'd5,
		ROLE_LF      = 3'd6,
		ROLE_BODY    = 3'd7
	} role_t;

	// Sticky error codes
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_TYPE  = 3'd1,
		ERR_EMPTY_DOM = 3'd2,
		ERR_ZERO_PORT = 3'd3,
		ERR_BAD_CRLF  = 3'd4,
		ERR_TOO_LONG  = 3'd5
	} err_t;

	// Address kind seen in the type byte
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_IPV4   = 2'd1,
		KIND_DOMAIN = 2'd2,
		KIND_IPV6   = 2'd3
	} kind_t;

	localparam logic [7:0] TYPE_IPV4   = 8'd1;
	localparam logic [7:0] TYPE_DOMAIN = 8'd3;
	localparam logic [7:0] TYPE_IPV6   = 8'd4;
	localparam logic [7:0] CHAR_CR     = 8'd13;
	localparam logic [7:0] CHAR_LF     = 8'd10;

	// Header byte counts (type byte up to LF inclusive)
	localparam logic [8:0] TARGET_START    = 9'd1;
	localparam logic [8:0] TARGET_IPV4     = 9'd11;
	localparam logic [8:0] TARGET_IPV6     = 9'd23;
	localparam logic [8:0] TARGET_DOM_LEN  = 9'd2;
	localparam logic [8:0] DOMAIN_OVERHEAD = 9'd8;
	localparam logic [8:0] HEADER_MAX      = 9'd263;

	localparam int unsigned QUEUE_DEPTH = 2;

	// One classified word, as it travels from front to back
	typedef struct packed {
		logic [7:0]  data;
		role_t       role;
		logic        done;
		logic [15:0] port;
		logic [15:0] size;
		logic        last;
		err_t        err;
	} res_t;

	// Queue status seen by the input handshake in the top level and by the back end
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

endpackage

### rtl/utfhp_front.sv
// Front end: accepts stream bytes, tracks header position and tags each word.
// Depends on utfhp_pkg.

module utfhp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic [15:0]          max_len,
	output utfhp_pkg::res_t      res
);
	import utfhp_pkg::*;

	logic [8:0]  target_q;
	logic [8:0]  seen_q;
	kind_t       kind_q;
	logic [15:0] port_q;
	logic [15:0] len_q;
	logic        in_body_q;
	logic [15:0] remain_q;
	err_t        err_q;

	logic [8:0]  target_d;
	logic [8:0]  seen_d;
	kind_t       kind_d;
	logic [15:0] port_d;
	logic [15:0] len_d;
	logic        in_body_d;
	logic [15:0] remain_d;
	err_t        err_d;
	logic [15:0] remain_dec;
	logic [9:0]  pos_w;
	logic [9:0]  n_w;
	logic        restart;

	assign pos_w      = {1'b0, seen_q};
	assign n_w        = {1'b0, target_q};
	assign remain_dec = remain_q - 16'd1;

	// Classify the current byte and work out the next parser state
	always_comb begin
		target_d  = target_q;
		seen_d    = seen_q;
		kind_d    = kind_q;
		port_d    = port_q;
		len_d     = len_q;
		in_body_d = in_body_q;
		remain_d  = remain_q;
		err_d     = err_q;
		restart   = 1'b0;
		res.data  = data_byte;
		res.role  = ROLE_TYPE;
		res.done  = 1'b0;
		res.port  = '0;
		res.size  = '0;
		res.last  = 1'b0;

		priority if (err_q != ERR_NONE) begin
			// sticky error: pass through only
		end else if (in_body_q) begin
			res.role = ROLE_BODY;
			remain_d = remain_dec;
			if (remain_dec == 16'd0) begin
				res.last  = 1'b1;
				in_body_d = 1'b0;
				restart   = 1'b1;
			end
		end else begin
			seen_d = seen_q + 9'd1;
			priority if (seen_q == 9'd0) begin
				res.role = ROLE_TYPE;
				priority if (data_byte == TYPE_IPV4) begin
					kind_d   = KIND_IPV4;
					target_d = TARGET_IPV4;
				end else if (data_byte == TYPE_IPV6) begin
					kind_d   = KIND_IPV6;
					target_d = TARGET_IPV6;
				end else if (data_byte == TYPE_DOMAIN) begin
					kind_d   = KIND_DOMAIN;
					target_d = TARGET_DOM_LEN;
				end else begin
					err_d = ERR_BAD_TYPE;
				end
			end else if (kind_q == KIND_DOMAIN && target_q == TARGET_DOM_LEN) begin
				res.role = ROLE_DOM_LEN;
				if (data_byte == 8'd0)
					err_d = ERR_EMPTY_DOM;
				else
					target_d = DOMAIN_OVERHEAD + {1'b0, data_byte};
			end else if (pos_w + 10'd6 < n_w) begin
				res.role = ROLE_ADDR;
			end else if (pos_w + 10'd4 < n_w) begin
				res.role = ROLE_PORT;
				port_d   = {port_q[7:0], data_byte};
			end else if (pos_w + 10'd2 < n_w) begin
				res.role = ROLE_LENGTH;
				len_d    = {len_q[7:0], data_byte};
			end else if (pos_w + 10'd2 == n_w) begin
				res.role = ROLE_CR;
				if (port_q == 16'd0)
					err_d = ERR_ZERO_PORT;
				else if (data_byte != CHAR_CR)
					err_d = ERR_BAD_CRLF;
			end else begin
				res.role = ROLE_LF;
				priority if (data_byte != CHAR_LF) begin
					err_d = ERR_BAD_CRLF;
				end else if (len_q > max_len) begin
					err_d = ERR_TOO_LONG;
				end else begin
					res.done = 1'b1;
					res.port = port_q;
					res.size = len_q;
					if (len_q != 16'd0) begin
						in_body_d = 1'b1;
						remain_d  = len_q;
					end
					restart = 1'b1;
				end
			end
		end

		// new frame: clear header trackers
		if (restart) begin
			target_d = TARGET_START;
			seen_d   = '0;
			kind_d   = KIND_NONE;
			port_d   = '0;
			len_d    = '0;
		end
		res.err = err_d;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= TARGET_START;
			seen_q    <= '0;
			kind_q    <= KIND_NONE;
			port_q    <= '0;
			len_q     <= '0;
			in_body_q <= 1'b0;
			remain_q  <= '0;
			err_q     <= ERR_NONE;
		end else if (accept) begin
			target_q  <= target_d;
			seen_q    <= seen_d;
			kind_q    <= kind_d;
			port_q    <= port_d;
			len_q     <= len_d;
			in_body_q <= in_body_d;
			remain_q  <= remain_d;
			err_q     <= err_d;
		end
	end

	// An error never clears once latched
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ERR_NONE |=> err_q == $past(err_q))
		else $error("latched error changed");

	// Body tracking only starts from a clean header
	a_body_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> (err_q == ERR_NONE && remain_q != 16'd0))
		else $error("body state inconsistent");

	// Header position never runs past the longest header (an LF error freezes it there)
	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= HEADER_MAX)
		else $error("header position out of range");

endmodule

### rtl/utfhp_queue.sv
// Short queue between front and back so that each side stalls on its own.
// Depends on utfhp_pkg.

module utfhp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  utfhp_pkg::res_t      push_data,
	input  logic                 pop,
	output utfhp_pkg::res_t      head,
	output utfhp_pkg::q_stat_t   stat
);
	import utfhp_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	res_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head           = mem_q[rd_ptr_q];
	assign stat.full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.not_empty = (count_q != '0);

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !stat.not_empty))
		else $error("pop from empty queue");

endmodule

### rtl/utfhp_back.sv
// Back end: output register fed from the queue head, drives the result word.
// Depends on utfhp_pkg.

module utfhp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utfhp_pkg::q_stat_t   stat,
	input  utfhp_pkg::res_t      head,
	output logic                 pop,
	input  logic                 out_stall,
	output logic                 out_valid,
	output utfhp_pkg::res_t      out_res
);
	import utfhp_pkg::*;

	logic valid_q;
	res_t res_q;

	// Refill whenever the register is empty or being taken
	assign pop       = stat.not_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= stat.not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= head;
	end

endmodule

### rtl/udp_tunnel_frame_header_parser_core.sv
// Tunnelled UDP frame header parser, top level.
// An accepted byte is written into the queue, then moved into the output register, before it shows as a result word.
// Throughput: one byte per cycle while data_stall is low; the 2-word queue and output register decouple sides.
// Reset (arst_n low): parser returns to frame start, errors clear, queue and
// output empty, the body length limit register returns to 65535.
// Depends on utfhp_pkg, utfhp_front, utfhp_queue, utfhp_back.

module udp_tunnel_frame_header_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        max_body_length_we,
	input  logic [15:0] max_body_length,
	// byte input
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	// result output
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  byte_out,
	output logic [2:0]  byte_role,
	output logic        header_done,
	output logic [15:0] dest_port,
	output logic [15:0] body_size,
	output logic        body_last,
	output logic [2:0]  error_code
);
	import utfhp_pkg::*;

	logic [15:0] max_len_q;
	logic        accept;
	logic        pop;
	res_t        front_res;
	res_t        head;
	res_t        out_res;
	q_stat_t     stat;

	// Body length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_len_q <= 16'hFFFF;
		else if (max_body_length_we)
			max_len_q <= max_body_length;
	end

	assign data_stall = stat.full;
	assign accept     = data_valid && !stat.full;

	utfhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.max_len   (max_len_q),
		.res       (front_res)
	);

	utfhp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_res),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	utfhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.head      (head),
		.pop       (pop),
		.out_stall (result_stall),
		.out_valid (result_valid),
		.out_res   (out_res)
	);

	assign byte_out    = out_res.data;
	assign byte_role   = out_res.role;
	assign header_done = out_res.done;
	assign dest_port   = out_res.port;
	assign body_size   = out_res.size;
	assign body_last   = out_res.last;
	assign error_code  = out_res.err;

endmodule
